// ===== rtl/core/i2cee_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cee_pkg
// Shared types and constants of the I2C EEPROM master sequencer.
// ----------------------------------------------------------------------------
package i2cee_pkg;

  // command codes
  localparam logic [1:0] CmdNone  = 2'd0;
  localparam logic [1:0] CmdWrite = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CfgCtrlIdx   = 2'd0;
  localparam logic [1:0] CfgTwoByteIdx = 2'd1;
  localparam logic [1:0] CfgThreshIdx = 2'd2;

  localparam int unsigned CfgDataWidth = 16;

  // configuration reset values
  localparam logic [7:0]  CtrlReset    = 8'd160;
  localparam logic        TwoByteReset = 1'b1;
  localparam logic [15:0] ThreshReset  = 16'd64000;

  localparam logic [7:0] WriteDirMask = 8'hFE;
  localparam logic [7:0] BankSelBit   = 8'h02;
  localparam logic [7:0] ReadDirBit   = 8'h01;

  typedef enum logic [4:0] {
    PhIdle      = 5'd0,
    PhWStart    = 5'd1,
    PhWCtrl     = 5'd2,
    PhWAhi      = 5'd3,
    PhWAlo      = 5'd4,
    PhWReq      = 5'd5,
    PhWData     = 5'd6,
    PhWStop     = 5'd7,
    PhPStart    = 5'd8,
    PhPCtrl     = 5'd9,
    PhPStop     = 5'd10,
    PhRStart    = 5'd11,
    PhRCtrl     = 5'd12,
    PhRAhi      = 5'd13,
    PhRAlo      = 5'd14,
    PhRRestart  = 5'd15,
    PhRCtrlRd   = 5'd16,
    PhRData     = 5'd17,
    PhRStop     = 5'd18
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic [1:0]  pin_step;
    logic [3:0]  bit_count;
    logic [7:0]  shift_reg;
    logic [7:0]  bytes_left;
    logic [15:0] held_address;
    logic [7:0]  working_control;
    logic        scl;
    logic        sda;
  } seq_state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] mem_address;
    logic [7:0]  byte_count;
    logic [7:0]  write_byte;
    logic        write_valid;
    logic        sda_in;
  } tick_in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_released;
    logic       busy_res;
    logic       data_request;
    logic       read_valid;
    logic [7:0] read_data;
    logic       read_last;
    logic       done_res;
  } tick_out_t;

  typedef struct packed {
    logic [7:0]  device_control_byte;
    logic        two_byte_address;
    logic [15:0] bank_threshold;
  } cfg_t;

endpackage

// ===== rtl/core/i2cee_in_if.sv =====
// ----------------------------------------------------------------------------
// i2cee_in_if
// Tick request channel: command, transfer fields and the sampled SDA level.
// ----------------------------------------------------------------------------
interface i2cee_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] mem_address;
  logic [7:0]  byte_count;
  logic [7:0]  write_byte;
  logic        write_valid;
  logic        sda_in;

  modport source (
    output valid, command, mem_address, byte_count, write_byte, write_valid, sda_in,
    input  ready
  );
  modport sink (
    input  valid, command, mem_address, byte_count, write_byte, write_valid, sda_in,
    output ready
  );
endinterface

// ===== rtl/core/i2cee_out_if.sv =====
// ----------------------------------------------------------------------------
// i2cee_out_if
// Tick result channel: pin levels, status and received bytes.
// ----------------------------------------------------------------------------
interface i2cee_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_released;
  logic       busy_res;
  logic       data_request;
  logic       read_valid;
  logic [7:0] read_data;
  logic       read_last;
  logic       done_res;

  modport source (
    output valid, scl_level, sda_released, busy_res, data_request, read_valid,
           read_data, read_last, done_res,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_released, busy_res, data_request, read_valid,
           read_data, read_last, done_res,
    output ready
  );
endinterface

// ===== rtl/core/i2cee_step.sv =====
// ----------------------------------------------------------------------------
// i2cee_step
// Next-state logic of the sequencer: one pin step per tick.
// ----------------------------------------------------------------------------
module i2cee_step
  import i2cee_pkg::*;
(
  input  seq_state_t state_i,
  input  tick_in_t   tick_i,
  input  cfg_t       cfg_i,
  output seq_state_t state_o,
  output tick_out_t  result_o
);

  function automatic seq_state_t go_to(seq_state_t s, phase_e p, logic [7:0] load);
    seq_state_t r;
    r           = s;
    r.phase     = p;
    r.shift_reg = load;
    r.bit_count = 4'd0;
    r.pin_step  = 2'd0;
    return r;
  endfunction

  seq_state_t s;
  logic       fin;
  logic       ack;
  logic       last_byte;
  logic [7:0] ctrl;
  logic       req;
  logic       rvalid;
  logic [7:0] rdata;
  logic       rlast;
  logic       done;

  always_comb begin
    s      = state_i;
    fin    = 1'b0;
    ack    = 1'b0;
    req    = 1'b0;
    rvalid = 1'b0;
    rdata  = 8'd0;
    rlast  = 1'b0;
    done   = 1'b0;
    ctrl   = cfg_i.device_control_byte & WriteDirMask;

    // command tick also performs the first start step
    if (s.phase == PhIdle && (tick_i.command == CmdWrite || tick_i.command == CmdRead)) begin
      if (cfg_i.two_byte_address && tick_i.mem_address >= cfg_i.bank_threshold) begin
        ctrl = ctrl | BankSelBit;
      end
      s.working_control = ctrl;
      s.held_address    = tick_i.mem_address;
      s.bytes_left      = tick_i.byte_count;
      s = go_to(s, (tick_i.command == CmdWrite) ? PhWStart : PhRStart, 8'd0);
    end

    last_byte = (s.bytes_left <= 8'd1);

    case (s.phase)
      PhWStart, PhPStart, PhRStart, PhRRestart: begin
        case (s.pin_step)
          2'd0: begin
            s.sda = 1'b1;
            s.pin_step = 2'd1;
          end
          2'd1: begin
            s.scl = 1'b1;
            s.pin_step = 2'd2;
          end
          2'd2: begin
            s.sda = 1'b0;
            s.pin_step = 2'd3;
          end
          default: begin
            s.scl = 1'b0;
            fin = 1'b1;
          end
        endcase
        if (fin) begin
          case (s.phase)
            PhWStart: s = go_to(s, PhWCtrl, s.working_control);
            PhPStart: s = go_to(s, PhPCtrl, s.working_control);
            PhRStart: s = go_to(s, PhRCtrl, s.working_control);
            default:  s = go_to(s, PhRCtrlRd, s.working_control | ReadDirBit);
          endcase
        end
      end

      PhWStop, PhPStop, PhRStop: begin
        case (s.pin_step)
          2'd0: begin
            s.scl = 1'b0;
            s.sda = 1'b0;
            s.pin_step = 2'd1;
          end
          2'd1: begin
            s.scl = 1'b1;
            s.pin_step = 2'd2;
          end
          default: begin
            s.sda = 1'b1;
            fin = 1'b1;
          end
        endcase
        if (fin) begin
          if (s.phase == PhWStop) begin
            s = go_to(s, PhPStart, 8'd0);
          end else begin
            s = go_to(s, PhIdle, 8'd0);
            done = 1'b1;
          end
        end
      end

      PhWReq: begin
        req = 1'b1;
        if (tick_i.write_valid) begin
          s = go_to(s, PhWData, tick_i.write_byte);
        end
      end

      PhRData: begin
        if (!s.bit_count[3]) begin
          // data bits: sample while scl is high
          case (s.pin_step)
            2'd0: begin
              s.scl = 1'b0;
              s.sda = 1'b1;
              s.pin_step = 2'd1;
            end
            2'd1: begin
              s.scl = 1'b1;
              s.shift_reg = {s.shift_reg[6:0], tick_i.sda_in};
              s.pin_step = 2'd2;
            end
            default: begin
              s.scl = 1'b0;
              s.bit_count = s.bit_count + 4'd1;
              s.pin_step = 2'd0;
            end
          endcase
        end else begin
          // ack or nak on the last byte
          case (s.pin_step)
            2'd0: begin
              s.scl = 1'b0;
              s.sda = last_byte;
              s.pin_step = 2'd1;
            end
            2'd1: begin
              s.scl = 1'b1;
              s.pin_step = 2'd2;
            end
            default: begin
              s.scl = 1'b0;
              fin = 1'b1;
            end
          endcase
        end
        if (fin) begin
          rvalid = 1'b1;
          rdata  = s.shift_reg;
          rlast  = last_byte;
          if (s.bytes_left != 8'd0) begin
            s.bytes_left = s.bytes_left - 8'd1;
          end
          s = go_to(s, (s.bytes_left != 8'd0) ? PhRData : PhRStop, 8'd0);
        end
      end

      PhWCtrl, PhWAhi, PhWAlo, PhWData, PhPCtrl, PhRCtrl, PhRAhi, PhRAlo, PhRCtrlRd: begin
        if (!s.bit_count[3]) begin
          case (s.pin_step)
            2'd0: begin
              s.scl = 1'b0;
              s.sda = s.shift_reg[7];
              s.pin_step = 2'd1;
            end
            2'd1: begin
              s.scl = 1'b1;
              s.pin_step = 2'd2;
            end
            default: begin
              s.scl = 1'b0;
              s.shift_reg = {s.shift_reg[6:0], 1'b0};
              s.bit_count = s.bit_count + 4'd1;
              s.pin_step = 2'd0;
            end
          endcase
        end else begin
          // release sda and sample the device acknowledge
          case (s.pin_step)
            2'd0: begin
              s.scl = 1'b0;
              s.sda = 1'b1;
              s.pin_step = 2'd1;
            end
            2'd1: begin
              s.scl = 1'b1;
              s.shift_reg = {7'd0, tick_i.sda_in};
              s.pin_step = 2'd2;
            end
            default: begin
              s.scl = 1'b0;
              fin = 1'b1;
            end
          endcase
        end
        if (fin) begin
          ack = s.shift_reg[0];
          case (s.phase)
            PhWCtrl: begin
              if (cfg_i.two_byte_address) s = go_to(s, PhWAhi, s.held_address[15:8]);
              else s = go_to(s, PhWAlo, s.held_address[7:0]);
            end
            PhRCtrl: begin
              if (cfg_i.two_byte_address) s = go_to(s, PhRAhi, s.held_address[15:8]);
              else s = go_to(s, PhRAlo, s.held_address[7:0]);
            end
            PhWAhi: s = go_to(s, PhWAlo, s.held_address[7:0]);
            PhRAhi: s = go_to(s, PhRAlo, s.held_address[7:0]);
            PhWAlo: s = go_to(s, (s.bytes_left != 8'd0) ? PhWReq : PhWStop, 8'd0);
            PhRAlo: s = go_to(s, PhRRestart, 8'd0);
            PhWData: begin
              if (s.bytes_left != 8'd0) begin
                s.bytes_left = s.bytes_left - 8'd1;
              end
              s = go_to(s, (s.bytes_left != 8'd0) ? PhWReq : PhWStop, 8'd0);
            end
            // a nak while polling repeats the poll
            PhPCtrl: s = go_to(s, ack ? PhPStart : PhPStop, 8'd0);
            default: s = go_to(s, (s.bytes_left != 8'd0) ? PhRData : PhRStop, 8'd0);
          endcase
        end
      end

      default: begin
        if (s.phase != PhIdle) begin
          s = go_to(s, PhIdle, 8'd0);
        end
      end
    endcase
  end

  assign state_o = s;

  assign result_o.scl_level    = s.scl;
  assign result_o.sda_released = s.sda;
  assign result_o.busy_res     = (s.phase != PhIdle);
  assign result_o.data_request = req;
  assign result_o.read_valid   = rvalid;
  assign result_o.read_data    = rdata;
  assign result_o.read_last    = rlast;
  assign result_o.done_res     = done;

endmodule

// ===== rtl/core/i2c_eeprom_master_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_eeprom_master_sequencer_unit
// Tick-driven I2C master for serial EEPROMs with page write, ack polling
// and sequential read.
//
//   channel   dir  handshake            contents
//   req_i     in   valid/ready          command, address, count, write byte, sda
//   res_o     out  valid/ready          scl, sda release, status, read byte
//   cfg_*     in   write enable only    control byte, address mode, threshold
//
// Each request is one tick: it is taken into the input register, advanced
// through the combinational step logic, and lands in the result register.
// One request per cycle is sustained while res_o.ready is not held low.
// A waiting result keeps the input register from advancing; a stalled
// result holds the bus state and the step logic until res_o.ready returns.
// Reset leaves the bus idle with scl and sda released.
// ----------------------------------------------------------------------------
module i2c_eeprom_master_sequencer_unit
  import i2cee_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  i2cee_in_if.sink                req_i,
  i2cee_out_if.source             res_o,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i
);

  cfg_t       cfg_q;
  seq_state_t state_q;
  seq_state_t state_d;
  tick_in_t   in_q;
  logic       in_vld_q;
  tick_out_t  res_q;
  tick_out_t  res_d;
  logic       out_vld_q;
  logic       advance;

  assign advance     = in_vld_q && (!out_vld_q || res_o.ready);
  assign req_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_control_byte <= CtrlReset;
      cfg_q.two_byte_address    <= TwoByteReset;
      cfg_q.bank_threshold      <= ThreshReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCtrlIdx:    cfg_q.device_control_byte <= cfg_wdata_i[7:0];
        CfgTwoByteIdx: cfg_q.two_byte_address    <= cfg_wdata_i[0];
        CfgThreshIdx:  cfg_q.bank_threshold      <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.command     <= req_i.command;
      in_q.mem_address <= req_i.mem_address;
      in_q.byte_count  <= req_i.byte_count;
      in_q.write_byte  <= req_i.write_byte;
      in_q.write_valid <= req_i.write_valid;
      in_q.sda_in      <= req_i.sda_in;
    end
  end

  i2cee_step u_step (
    .state_i  (state_q),
    .tick_i   (in_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{phase: PhIdle, pin_step: 2'd0, bit_count: 4'd0, shift_reg: 8'd0,
                     bytes_left: 8'd0, held_address: 16'd0, working_control: 8'd0,
                     scl: 1'b1, sda: 1'b1};
    end else begin
      if (req_i.valid && req_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        state_q   <= state_d;
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.scl_level    = res_q.scl_level;
  assign res_o.sda_released = res_q.sda_released;
  assign res_o.busy_res     = res_q.busy_res;
  assign res_o.data_request = res_q.data_request;
  assign res_o.read_valid   = res_q.read_valid;
  assign res_o.read_data    = res_q.read_data;
  assign res_o.read_last    = res_q.read_last;
  assign res_o.done_res     = res_q.done_res;

  // a received byte never ends the transaction on its own tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.read_valid |-> res_q.busy_res && !res_q.data_request)
    else $error("read byte reported outside a busy transaction");

  // the final stop leaves both lines released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.done_res |-> !res_q.busy_res && res_q.scl_level
                                    && res_q.sda_released)
    else $error("done without a released bus");

  // while a write byte is awaited the clock is held low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PhWReq |-> !state_q.scl)
    else $error("scl high while waiting for write data");

  // bus state moves only when a request is stepped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("bus state changed without a request");

  // idle bus has both lines released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PhIdle |-> state_q.scl && state_q.sda)
    else $error("idle with a line driven low");

endmodule
